### hw/rtl/pal_pkg.sv
// Shared types and constants for the positional array list.
// Used by pal_ctrl and positional_array_list_top; no dependencies.
package pal_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_LOCATE = 2'd2,
    FUNC_GET    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_INS,
    ST_REPLY
  } pal_state_t;

  typedef struct packed {
    func_t                    func;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } pal_in_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] data_out;
    logic [POS_W-1:0]         found_position;
    logic [POS_W-1:0]         count;
    logic                     empty_res;
  } pal_out_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } pal_mem_req_t;

endpackage

### hw/rtl/pal_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port,
// registered read data. No dependencies.
module pal_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/pal_ctrl.sv
// Operation sequencer for the positional array list: walks the element RAM
// with pipelined read/write-back to shift, scan and read entries.
// Depends on pal_pkg.
module pal_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  pal_pkg::pal_in_t           in_data,
  output logic                       busy,
  output logic                       out_valid,
  output pal_pkg::pal_out_t          out_data,
  output pal_pkg::pal_mem_req_t      mem_req,
  input  logic [pal_pkg::DATA_W-1:0] mem_rdata
);
  import pal_pkg::*;

  pal_state_t        state_r, state_nxt;
  func_t             op_r, op_nxt;
  logic [ADDR_W-1:0] pos_idx_r, pos_idx_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic [ADDR_W-1:0] end_r, end_nxt;
  logic [ADDR_W-1:0] rlast_r, rlast_nxt;
  logic              rv_r, rv_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  logic [POS_W-1:0]  found_r, found_nxt;
  logic              ok_r, ok_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  pal_out_t          out_data_r, out_data_nxt;

  logic [POS_W-1:0]  pos_m1;
  logic [CNT_W-1:0]  cnt_m1;
  logic [POS_W:0]    pos_x;
  logic [POS_W:0]    cnt_x;
  logic              hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    pos_idx_r  <= pos_idx_nxt;
    ptr_r      <= ptr_nxt;
    end_r      <= end_nxt;
    rlast_r    <= rlast_nxt;
    val_r      <= val_nxt;
    data_r     <= data_nxt;
    found_r    <= found_nxt;
    ok_r       <= ok_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    pos_idx_nxt   = pos_idx_r;
    ptr_nxt       = ptr_r;
    end_nxt       = end_r;
    rlast_nxt     = rlast_r;
    rv_nxt        = rv_r;
    val_nxt       = val_r;
    data_nxt      = data_r;
    found_nxt     = found_r;
    ok_nxt        = ok_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    mem_req       = '0;
    hit           = 1'b0;

    pos_m1 = in_data.position - 1'b1;
    cnt_m1 = cnt_r - 1'b1;
    pos_x  = {1'b0, in_data.position};
    cnt_x  = (POS_W + 1)'(cnt_r);

    // Consume the word read in the previous cycle.
    if (rv_r) begin
      unique case (op_r)
        FUNC_INSERT: begin
          mem_req.we    = 1'b1;
          mem_req.waddr = rlast_r + 1'b1;
          mem_req.wdata = mem_rdata;
        end
        FUNC_DELETE: begin
          if (rlast_r == pos_idx_r) begin
            data_nxt = mem_rdata;
          end else begin
            mem_req.we    = 1'b1;
            mem_req.waddr = rlast_r - 1'b1;
            mem_req.wdata = mem_rdata;
          end
        end
        FUNC_LOCATE: begin
          if (mem_rdata == val_r) begin
            hit       = 1'b1;
            ok_nxt    = 1'b1;
            found_nxt = POS_W'(rlast_r) + 1'b1;
          end
        end
        FUNC_GET: begin
          data_nxt = mem_rdata;
        end
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt      = in_data.func;
          val_nxt     = in_data.value;
          pos_idx_nxt = pos_m1[ADDR_W-1:0];
          rv_nxt      = 1'b0;
          data_nxt    = '0;
          found_nxt   = '0;
          ok_nxt      = 1'b0;
          state_nxt   = ST_REPLY;
          unique case (in_data.func)
            FUNC_INSERT: begin
              if (pos_x != '0 && pos_x <= cnt_x + 1'b1 && cnt_r < CNT_W'(CAPACITY)) begin
                ok_nxt  = 1'b1;
                ptr_nxt = cnt_m1[ADDR_W-1:0];
                end_nxt = pos_m1[ADDR_W-1:0];
                // Append needs no shift.
                state_nxt = (pos_x == cnt_x + 1'b1) ? ST_INS : ST_WALK;
              end
            end
            FUNC_DELETE: begin
              if (pos_x != '0 && pos_x <= cnt_x) begin
                ok_nxt    = 1'b1;
                ptr_nxt   = pos_m1[ADDR_W-1:0];
                end_nxt   = cnt_m1[ADDR_W-1:0];
                state_nxt = ST_WALK;
              end
            end
            FUNC_LOCATE: begin
              if (cnt_r != '0) begin
                ptr_nxt   = '0;
                end_nxt   = cnt_m1[ADDR_W-1:0];
                state_nxt = ST_WALK;
              end
            end
            FUNC_GET: begin
              if (pos_x != '0 && pos_x <= cnt_x) begin
                ok_nxt    = 1'b1;
                ptr_nxt   = pos_m1[ADDR_W-1:0];
                end_nxt   = pos_m1[ADDR_W-1:0];
                state_nxt = ST_WALK;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (op_r == FUNC_LOCATE && hit) begin
          // Drop the rest of the scan at the first match.
          rv_nxt    = 1'b0;
          state_nxt = ST_REPLY;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = ptr_r;
          rv_nxt        = 1'b1;
          rlast_nxt     = ptr_r;
          if (ptr_r == end_r) begin
            state_nxt = ST_DRAIN;
          end else if (op_r == FUNC_INSERT) begin
            ptr_nxt = ptr_r - 1'b1;
          end else begin
            ptr_nxt = ptr_r + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        rv_nxt    = 1'b0;
        state_nxt = (op_r == FUNC_INSERT) ? ST_INS : ST_REPLY;
      end
      ST_INS: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos_idx_r;
        mem_req.wdata = val_r;
        state_nxt     = ST_REPLY;
      end
      ST_REPLY: begin
        if (ok_r && op_r == FUNC_INSERT) begin
          cnt_nxt = cnt_r + 1'b1;
        end else if (ok_r && op_r == FUNC_DELETE) begin
          cnt_nxt = cnt_r - 1'b1;
        end
        out_valid_nxt               = 1'b1;
        out_data_nxt.ok             = ok_r;
        out_data_nxt.data_out       = data_r;
        out_data_nxt.found_position = found_r;
        out_data_nxt.count          = POS_W'(cnt_nxt);
        out_data_nxt.empty_res      = (cnt_nxt == '0);
        state_nxt                   = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we && mem_req.re |-> mem_req.waddr != mem_req.raddr)
    else $error("RAM read and write hit the same entry");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("transfer accepted but sequencer not busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && !rv_r)
    else $error("result issued while an operation is in flight");

endmodule

### hw/rtl/positional_array_list_top.sv
// Positional array list: an ordered list of up to CAPACITY signed 32-bit
// words with 1-based positions, supporting insert, delete, locate and get.
// Depends on pal_pkg, pal_ram and pal_ctrl.
//
// An operation is taken when start is high and busy is low; busy then stays
// high until the single result appears on out_data with out_valid high for
// one cycle, which the receiver must take (it cannot stall). A rejected
// operation goes straight to its result; get reads one entry, delete shifts
// the entries after the position down, locate compares entries until the
// first match, and insert shifts the entries from the position up before
// writing the new value (an append writes it at once). Run time is set by
// the element RAM, which moves one word per cycle through its single read
// and single write port. A new operation may be started in the cycle the
// result is shown. The list is empty after reset and needs no clearing pass.
module positional_array_list_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  pal_pkg::pal_in_t   in_data,
  output logic               busy,
  output logic               out_valid,
  output pal_pkg::pal_out_t  out_data
);
  import pal_pkg::*;

  pal_mem_req_t      mem_req;
  logic [DATA_W-1:0] mem_rdata;

  pal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  pal_ram #(
    .DEPTH  (CAPACITY),
    .WIDTH  (DATA_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

endmodule
